// ----- src/ist_pkg.sv -----
// ----------------------------------------------------------------------------
// Incubation slot timers package
// Shared constants, codes and types for the incubation slot timer block.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int Slots      = 6;
  localparam int SlotShift  = 2;
  localparam int CntW       = 13;
  localparam int WordW      = 16;
  localparam int MaskW      = 6;
  localparam int SlotNumW   = 3;

  localparam logic [CntW-1:0] IncubReset = CntW'(60 * 6);
  localparam logic [CntW-1:0] IncubMin   = CntW'(10);
  localparam logic [CntW-1:0] IncubMax   = CntW'(3600 * 2);

  localparam int BitPowerHome = 0;
  localparam int BitCardHome  = 1;

  localparam logic CmdTick     = 1'b0;
  localparam logic CmdSample   = 1'b1;
  localparam logic KindStatus  = 1'b0;
  localparam logic KindTimeout = 1'b1;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [Slots-1:0] slot_vec_t;

  typedef struct packed {
    logic              cmd;
    logic [WordW-1:0]  switch_word;
  } item_t;

endpackage

// ----- src/ist_cfg.sv -----
// ----------------------------------------------------------------------------
// Incubation time register
// Holds the incubation time; writes outside the legal range are ignored.
// ----------------------------------------------------------------------------
module ist_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  ist_pkg::cnt_t    cfg_wdata,
  output ist_pkg::cnt_t    incub_seconds
);
  import ist_pkg::*;

  logic in_range;

  assign in_range = (cfg_wdata >= IncubMin) && (cfg_wdata <= IncubMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      incub_seconds <= IncubReset;
    end else if (cfg_we && in_range) begin
      incub_seconds <= cfg_wdata;
    end
  end

endmodule

// ----- src/ist_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input word until the timer core takes it.
// ----------------------------------------------------------------------------
module ist_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ist_pkg::item_t  in_item,
  output logic            item_valid,
  output ist_pkg::item_t  item,
  input  logic            take
);
  import ist_pkg::*;

  logic accept;

  assign in_ready = !item_valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// ----- src/ist_core.sv -----
// ----------------------------------------------------------------------------
// Timer core
// Updates slot presence and counters, queues expiries and drives the result
// register, one result word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ist_core (
  input  logic                     clk,
  input  logic                     rst,
  input  ist_pkg::cnt_t            incub_seconds,
  input  logic                     item_valid,
  input  ist_pkg::item_t           item,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     kind,
  output logic                     power_on_home,
  output logic                     card_home,
  output logic [ist_pkg::MaskW-1:0]    present_mask,
  output logic [ist_pkg::SlotNumW-1:0] timeout_slot,
  output logic                     last
);
  import ist_pkg::*;

  slot_vec_t slot_present, slot_present_next;
  slot_vec_t pend, pend_next;
  cnt_t      cnt [Slots];
  cnt_t      cnt_next [Slots];
  logic      out_valid_next;

  logic                 out_free;
  logic                 emit;
  logic                 load_out;
  logic                 kind_d, poh_d, ch_d, last_d;
  logic [MaskW-1:0]     mask_d;
  logic [SlotNumW-1:0]  slot_d;
  slot_vec_t            low_bit;
  slot_vec_t            cur;
  slot_vec_t            expired;

  assign out_free = !out_valid || out_ready;
  assign emit     = (pend != '0) && out_free;
  assign take     = item_valid && (pend == '0) && ((item.cmd == CmdTick) || out_free);
  assign low_bit  = pend & (~pend + 1'b1);
  assign cur      = item.switch_word[SlotShift +: Slots];

  always_comb begin
    slot_present_next = slot_present;
    pend_next         = pend;
    cnt_next          = cnt;
    expired           = '0;
    load_out          = 1'b0;
    kind_d            = KindStatus;
    poh_d             = 1'b0;
    ch_d              = 1'b0;
    mask_d            = MaskW'(slot_present);
    slot_d            = '0;
    last_d            = 1'b1;
    if (emit) begin
      pend_next = pend & ~low_bit;
      load_out  = 1'b1;
      kind_d    = KindTimeout;
      last_d    = ((pend & ~low_bit) == '0);
      for (int i = Slots - 1; i >= 0; i--) begin
        if (pend[i]) begin
          slot_d = SlotNumW'(i + 1);
        end
      end
    end else if (take) begin
      if (item.cmd == CmdSample) begin
        for (int i = 0; i < Slots; i++) begin
          if (cur[i] && !slot_present[i]) begin
            cnt_next[i] = incub_seconds;
          end else if (!cur[i] && slot_present[i]) begin
            cnt_next[i] = '0;
          end
        end
        slot_present_next = cur;
        load_out          = 1'b1;
        poh_d             = item.switch_word[BitPowerHome];
        ch_d              = item.switch_word[BitCardHome];
        mask_d            = MaskW'(cur);
      end else begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_present[i] && (cnt[i] != '0)) begin
            cnt_next[i] = cnt[i] - 1'b1;
            expired[i]  = (cnt[i] == CntW'(1));
          end
        end
        pend_next = expired;
      end
    end
  end

  assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_present <= '0;
      pend         <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      slot_present <= slot_present_next;
      pend         <= pend_next;
      out_valid    <= out_valid_next;
      cnt          <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind          <= kind_d;
      power_on_home <= poh_d;
      card_home     <= ch_d;
      present_mask  <= mask_d;
      timeout_slot  <= slot_d;
      last          <= last_d;
    end
  end

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    (pend != '0) |-> !take)
    else $error("Input word taken while expiries are still queued.");

  a_sample_gives_status: assert property (@(posedge clk) disable iff (rst)
    (take && item.cmd == CmdSample) |=> (out_valid && kind == KindStatus && last))
    else $error("Switch sample did not produce a status word.");

  a_pending_present: assert property (@(posedge clk) disable iff (rst)
    (pend & ~slot_present) == '0)
    else $error("Expiry queued for an empty slot.");

  a_timeout_slot_named: assert property (@(posedge clk) disable iff (rst)
    $past(emit) |-> (out_valid && kind == KindTimeout && timeout_slot != '0))
    else $error("Timeout word without a slot number.");

  for (genvar g = 0; g < Slots; g++) begin : g_chk
    a_empty_slot_idle: assert property (@(posedge clk) disable iff (rst)
      !slot_present[g] |-> (cnt[g] == '0))
      else $error("Counter running for an empty slot.");
  end

endmodule

// ----- src/incubation_slot_timers_unit.sv -----
// ----------------------------------------------------------------------------
// Incubation slot timers
// Per-slot incubation countdowns driven by switch samples and second ticks.
// ----------------------------------------------------------------------------
// Sample status words pass the input and result registers; tick timeout words
// pass the input register, expiry queue and result register, which sets their
// rate of one word per cycle while out_ready is high. Samples are accepted
// every cycle while out_ready is high; queued expiries hold the next word.
// Reset clears presence, counters and queues, and loads 360 s.
module incubation_slot_timers_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ist_pkg::CntW-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [ist_pkg::WordW-1:0]     switch_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic                          power_on_home,
  output logic                          card_home,
  output logic [ist_pkg::MaskW-1:0]     present_mask,
  output logic [ist_pkg::SlotNumW-1:0]  timeout_slot,
  output logic                          last
);
  import ist_pkg::*;

  cnt_t  incub_seconds;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  take;

  assign in_item.cmd         = cmd;
  assign in_item.switch_word = switch_word;

  ist_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .incub_seconds (incub_seconds)
  );

  ist_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  ist_core u_core (
    .clk           (clk),
    .rst           (rst),
    .incub_seconds (incub_seconds),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .power_on_home (power_on_home),
    .card_home     (card_home),
    .present_mask  (present_mask),
    .timeout_slot  (timeout_slot),
    .last          (last)
  );

endmodule
